@@ hdl/ffp_pkg.sv @@
// ----------------------------------------------------------------------------
// ffp_pkg: shared types and constants of the frame fragment packetizer
// Holds header flag codes, config register indexes and the queue entry type.
// ----------------------------------------------------------------------------
package ffp_pkg;

	localparam int unsigned HEADER_BYTES = 8;

	localparam logic [15:0] MAX_PAYLOAD_RST = 16'd1452;
	localparam logic [7:0]  PACKET_TYPE_RST = 8'h00;

	// header flag codes (byte 2 of the header)
	localparam logic [1:0] FLAG_FIRST  = 2'd0;
	localparam logic [1:0] FLAG_MIDDLE = 2'd1;
	localparam logic [1:0] FLAG_LAST   = 2'd2;
	localparam logic [1:0] FLAG_SINGLE = 2'd3;

	// configuration register indexes
	localparam logic [7:0] REG_MAX_PAYLOAD = 8'd0;
	localparam logic [7:0] REG_PACKET_TYPE = 8'd1;

	// one classified payload byte, handed from front to back
	typedef struct packed {
		logic [7:0]  data;
		logic        hdr;
		logic [1:0]  flag;
		logic [15:0] seq;
		logic [7:0]  ptype;
		logic [31:0] size;
		logic        pend;
	} ffp_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} ffp_qstat_t;

endpackage

@@ hdl/ffp_front.sv @@
// ----------------------------------------------------------------------------
// ffp_front: input side of the packetizer
// Tracks frame and packet position, classifies each byte and queues it.
// ----------------------------------------------------------------------------
module ffp_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         data_byte,
	input  logic [31:0]        frame_size,
	input  logic [15:0]        max_payload,
	input  logic [7:0]         packet_type,
	input  logic               q_ready,
	output logic               q_push,
	output ffp_pkg::ffp_entry_t q_entry
);
	import ffp_pkg::*;

	logic [15:0] next_seq_q;
	logic [15:0] frame_seq_q;
	logic [31:0] rem_q;
	logic [31:0] size_q;
	logic [15:0] fill_q;

	logic        first;
	logic        drop;
	logic        take;
	logic [15:0] maxp;
	logic [31:0] cur_rem;
	logic [31:0] cur_size;
	logic [15:0] fill_n;
	logic        fits;

	assign in_ready = q_ready;
	assign take     = in_valid && in_ready;

	assign maxp     = (max_payload == 16'd0) ? 16'd1 : max_payload;
	assign first    = (rem_q == 32'd0);
	assign drop     = first && (frame_size == 32'd0);
	assign cur_rem  = first ? frame_size : rem_q;
	assign cur_size = first ? frame_size : size_q;
	assign fill_n   = (first ? 16'd0 : fill_q) + 16'd1;
	assign fits     = (cur_rem <= {16'd0, maxp});

	always_comb begin
		q_entry.data  = data_byte;
		q_entry.hdr   = first || (fill_q == 16'd0);
		if (fits) begin
			q_entry.flag = first ? FLAG_SINGLE : FLAG_LAST;
		end else begin
			q_entry.flag = first ? FLAG_FIRST : FLAG_MIDDLE;
		end
		q_entry.seq   = first ? next_seq_q : frame_seq_q;
		q_entry.ptype = packet_type;
		q_entry.size  = cur_size;
		q_entry.pend  = (fill_n >= maxp) || (cur_rem == 32'd1);
	end

	assign q_push = take && !drop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_seq_q  <= '0;
			frame_seq_q <= '0;
			rem_q       <= '0;
			size_q      <= '0;
			fill_q      <= '0;
		end else if (q_push) begin
			rem_q  <= cur_rem - 32'd1;
			size_q <= cur_size;
			fill_q <= q_entry.pend ? 16'd0 : fill_n;
			if (first) begin
				frame_seq_q <= next_seq_q;
				next_seq_q  <= next_seq_q + 16'd1;
			end
		end
	end

endmodule

@@ hdl/ffp_queue.sv @@
// ----------------------------------------------------------------------------
// ffp_queue: short FIFO between front and back
// Register-based, one push and one pop per cycle.
// ----------------------------------------------------------------------------
module ffp_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ffp_pkg::ffp_entry_t push_entry,
	output logic                push_ready,
	input  logic                pop,
	output logic                head_valid,
	output ffp_pkg::ffp_entry_t head_entry,
	output ffp_pkg::ffp_qstat_t stat
);
	import ffp_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	ffp_entry_t     mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push;
	logic           do_pop;

	assign stat.full   = (count_q == CW'(DEPTH));
	assign stat.empty  = (count_q == '0);
	assign push_ready  = !stat.full;
	assign head_valid  = !stat.empty;
	assign head_entry  = mem_q[rd_ptr_q];
	assign do_push     = push && push_ready;
	assign do_pop      = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ hdl/ffp_back.sv @@
// ----------------------------------------------------------------------------
// ffp_back: output side of the packetizer
// Expands queued bytes into header bytes plus payload into an output register.
// ----------------------------------------------------------------------------
module ffp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  ffp_pkg::ffp_entry_t head_entry,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          out_byte,
	output logic                is_header,
	output logic                packet_end,
	output logic                run_last
);
	import ffp_pkg::*;

	logic       valid_q;
	logic [7:0] byte_q;
	logic       hdr_q;
	logic       pend_q;
	logic       last_q;
	logic [2:0] cnt_q;
	logic       hdr_done_q;

	logic       load;
	logic       hdr_phase;
	logic [7:0] hbyte;

	assign load      = head_valid && (!valid_q || out_ready);
	assign hdr_phase = head_entry.hdr && !hdr_done_q;
	assign pop       = load && !hdr_phase;

	always_comb begin
		case (cnt_q)
			3'd0:    hbyte = head_entry.seq[15:8];
			3'd1:    hbyte = head_entry.seq[7:0];
			3'd2:    hbyte = {6'd0, head_entry.flag};
			3'd3:    hbyte = head_entry.ptype;
			3'd4:    hbyte = head_entry.size[31:24];
			3'd5:    hbyte = head_entry.size[23:16];
			3'd6:    hbyte = head_entry.size[15:8];
			default: hbyte = head_entry.size[7:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= 1'b0;
			cnt_q      <= '0;
			hdr_done_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
			if (load) begin
				if (hdr_phase) begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'(HEADER_BYTES - 1)) begin
						hdr_done_q <= 1'b1;
					end
				end else begin
					cnt_q      <= '0;
					hdr_done_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= hdr_phase ? hbyte : head_entry.data;
			hdr_q  <= hdr_phase;
			pend_q <= !hdr_phase && head_entry.pend;
			last_q <= !hdr_phase;
		end
	end

	assign out_valid  = valid_q;
	assign out_byte   = byte_q;
	assign is_header  = hdr_q;
	assign packet_end = pend_q;
	assign run_last   = last_q;

endmodule

@@ hdl/frame_fragment_packetizer.sv @@
// ----------------------------------------------------------------------------
// frame_fragment_packetizer: cuts frames into headed packets
// Streams frame bytes in and packet bytes (8-byte header plus payload) out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one payload byte per item with
//   the frame's total size; the size is sampled only on a frame's first byte.
//   A first byte with size zero is taken and dropped.
//   Output channel (out_valid/out_ready) carries one packet byte per item,
//   with is_header, packet_end and run_last marks.
//   Config channel (cfg_valid/cfg_ready) writes max_payload (index 0) and
//   packet_type (index 1); it is always ready. Write it only while idle.
// Timing:
//   An accepted byte goes through the queue and then the output register;
//   a byte that opens a packet follows eight header bytes on the output.
//   The output port sets the rate: one item per cycle while out_ready is
//   high and the queue holds bytes. The input takes bytes back to back
//   until the front/back queue (QUEUE_DEPTH) fills.
// Reset:
//   Clears the sequence counter, frame position and queue; config returns to
//   max_payload 1452, packet_type 0.
// Stall:
//   When out_ready is low the output register holds; the queue absorbs
//   incoming bytes and then in_ready drops.
// ----------------------------------------------------------------------------
module frame_fragment_packetizer #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic [31:0] frame_size,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        is_header,
	output logic        packet_end,
	output logic        run_last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import ffp_pkg::*;

	logic [15:0] max_payload_q;
	logic [7:0]  packet_type_q;

	logic        q_push;
	logic        q_ready;
	ffp_entry_t  q_in;
	logic        q_pop;
	logic        q_head_valid;
	ffp_entry_t  q_head;
	ffp_qstat_t  q_stat;

	// config registers: always ready, decode by index, ignore unknown indexes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= MAX_PAYLOAD_RST;
			packet_type_q <= PACKET_TYPE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MAX_PAYLOAD: max_payload_q <= cfg_data;
				REG_PACKET_TYPE: packet_type_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// front: track frame position, classify byte, push to queue
	ffp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_byte   (data_byte),
		.frame_size  (frame_size),
		.max_payload (max_payload_q),
		.packet_type (packet_type_q),
		.q_ready     (q_ready),
		.q_push      (q_push),
		.q_entry     (q_in)
	);

	// queue: decouple front from back so each stalls on its own
	ffp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_in),
		.push_ready (q_ready),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head_entry (q_head),
		.stat       (q_stat)
	);

	// back: emit header bytes when due, then the payload byte
	ffp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_head_valid),
		.head_entry (q_head),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.is_header  (is_header),
		.packet_end (packet_end),
		.run_last   (run_last)
	);

	// header bytes never close an item or a packet
	a_hdr_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_header |-> !run_last && !packet_end)
		else $error("header byte marked as last or packet end");

	// a full queue must back-pressure the input
	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full |-> !in_ready)
		else $error("input ready while queue full");

	// the back never pops an empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("pop from empty queue");

	// a packet-opening byte is popped only when the queue head was already valid before it
	a_header_before_open: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && q_head.hdr |-> $past(q_head_valid))
		else $error("packet opened without header phase");

endmodule

@@ bench/ffp_stream_checker.sv @@
// ----------------------------------------------------------------------------
// ffp_stream_checker: scoreboard for the frame fragment packetizer
// Watches the input, output and config channels, predicts the packet byte
// stream and compares every accepted output item against it.
// ----------------------------------------------------------------------------
module ffp_stream_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic [31:0] frame_size,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  out_byte,
	input  logic        is_header,
	input  logic        packet_end,
	input  logic        run_last,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          errors,
	output int          pending,
	output int          checked
);
	import ffp_pkg::*;

	typedef struct packed {
		logic [7:0] value;
		logic       head;
		logic       pend;
		logic       ends_run;
	} pkt_byte_t;

	pkt_byte_t   pkt_bytes_due[$];
	pkt_byte_t   want;
	int          err_cnt = 0;
	int          checked_cnt = 0;

	logic [15:0] cur_max_payload;
	logic [7:0]  cur_packet_type;
	logic [15:0] seq_next;
	logic [15:0] seq_frame;
	logic [31:0] frame_pos;
	logic [31:0] size_held;
	logic [15:0] fill;

	task automatic queue_header_byte(input logic [7:0] b);
		pkt_bytes_due.push_back('{value: b, head: 1'b1, pend: 1'b0, ends_run: 1'b0});
	endtask

	// expected packet bytes caused by one accepted frame byte
	task automatic packetize_byte(input logic [7:0] d, input logic [31:0] s);
		logic [31:0] maxp;
		logic [31:0] remaining;
		logic [31:0] chunk;
		logic [1:0]  flag;
		logic        closes;
		maxp = (cur_max_payload == 16'd0) ? 32'd1 : {16'd0, cur_max_payload};
		if (frame_pos == 32'd0) begin
			if (s == 32'd0)
				return;
			size_held = s;
			seq_frame = seq_next;
			seq_next  = seq_next + 16'd1;
			fill      = 16'd0;
		end
		if (fill == 16'd0) begin
			remaining = size_held - frame_pos;
			chunk     = (remaining > maxp) ? maxp : remaining;
			if (frame_pos == 32'd0 && size_held <= maxp)
				flag = FLAG_SINGLE;
			else if (chunk >= remaining)
				flag = FLAG_LAST;
			else if (frame_pos > 32'd0)
				flag = FLAG_MIDDLE;
			else
				flag = FLAG_FIRST;
			queue_header_byte(seq_frame[15:8]);
			queue_header_byte(seq_frame[7:0]);
			queue_header_byte({6'd0, flag});
			queue_header_byte(cur_packet_type);
			queue_header_byte(size_held[31:24]);
			queue_header_byte(size_held[23:16]);
			queue_header_byte(size_held[15:8]);
			queue_header_byte(size_held[7:0]);
		end
		frame_pos = frame_pos + 32'd1;
		fill      = fill + 16'd1;
		closes    = ({16'd0, fill} >= maxp) || (frame_pos >= size_held);
		pkt_bytes_due.push_back('{value: d, head: 1'b0, pend: closes, ends_run: 1'b1});
		if (closes)
			fill = 16'd0;
		if (frame_pos >= size_held)
			frame_pos = 32'd0;
	endtask

	task automatic check_field(input string name, input logic [7:0] exp_v, input logic [7:0] act_v);
		if (act_v !== exp_v) begin
			err_cnt++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_max_payload = MAX_PAYLOAD_RST;
			cur_packet_type = PACKET_TYPE_RST;
			seq_next  = '0;
			seq_frame = '0;
			frame_pos = '0;
			size_held = '0;
			fill      = '0;
			pkt_bytes_due.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MAX_PAYLOAD: cur_max_payload = cfg_data;
					REG_PACKET_TYPE: cur_packet_type = cfg_data[7:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (pkt_bytes_due.size() == 0) begin
					err_cnt++;
					$display("%0t: out_byte with nothing expected, expected none, actual %0h",
						$time, out_byte);
				end else begin
					want = pkt_bytes_due.pop_front();
					check_field("out_byte", want.value, out_byte);
					check_field("is_header", {7'd0, want.head}, {7'd0, is_header});
					check_field("packet_end", {7'd0, want.pend}, {7'd0, packet_end});
					check_field("run_last", {7'd0, want.ends_run}, {7'd0, run_last});
					checked_cnt++;
				end
			end
			if (in_valid && in_ready)
				packetize_byte(data_byte, frame_size);
		end
		errors  <= err_cnt;
		pending <= pkt_bytes_due.size();
		checked <= checked_cnt;
	end

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb: top of the frame fragment packetizer bench
// Drives frames of bytes and register writes into the packetizer, throttles
// the packet output, and reports the verdict from the stream checker.
// ----------------------------------------------------------------------------
module tb;
	import ffp_pkg::*;

	localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
	localparam int IDLE_LIMIT    = 4000;  // cycles without any handshake
	localparam int SETTLE_CYCLES = 16;    // quiet time before a register write
	localparam int RANDOM_ITEMS  = 110;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = '0;
	logic [31:0] frame_size = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  out_byte;
	logic        is_header;
	logic        packet_end;
	logic        run_last;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	int fail_count;
	int due_count;
	int compared_count;

	int burst_left = 0;
	int bytes_sent = 0;
	int frames_started = 0;
	int reg_writes = 0;
	int frame_left = 0;
	int random_sent = 0;
	int holds_done = 0;
	bit hold_req = 1'b0;

	int rx_mode = 0;
	int rx_left = 0;
	bit rx_toggle = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	frame_fragment_packetizer uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.data_byte(data_byte), .frame_size(frame_size),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_byte(out_byte), .is_header(is_header),
		.packet_end(packet_end), .run_last(run_last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	ffp_stream_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.data_byte(data_byte), .frame_size(frame_size),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_byte(out_byte), .is_header(is_header),
		.packet_end(packet_end), .run_last(run_last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(fail_count), .pending(due_count), .checked(compared_count)
	);

	// Receiver: switch between stall patterns, each chosen at random for a random
	// stretch. A hold request parks out_ready low for HOLD_CYCLES so the queue
	// fills and the input stalls while the sender keeps offering items.
	always begin
		@(posedge clk);
		if (hold_req) begin
			out_ready <= 1'b0;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_req = 1'b0;
			holds_done++;
		end
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(5, 60);
		end
		rx_left--;
		case (rx_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			2: out_ready <= ($urandom_range(0, 3) == 0);
			default: begin
				rx_toggle = ~rx_toggle;
				out_ready <= rx_toggle;
			end
		endcase
	end

	// Watchdog: end the run when no channel has moved an item for too long.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb: no handshake for %0d cycles", IDLE_LIMIT);
		$display("tb: failure");
		$finish;
	end

	// Offer one frame byte. Between bursts drop valid for a random gap, if any;
	// inside a burst, swap the payload at the accepting edge and keep valid high.
	task automatic offer_byte(input logic [7:0] d, input logic [31:0] s);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if ($urandom_range(0, 15) == 0)
				gap = $urandom_range(20, 40);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		in_valid   <= 1'b1;
		data_byte  <= d;
		frame_size <= s;
		do @(posedge clk); while (!in_ready);
		burst_left--;
		bytes_sent++;
	endtask

	// Send count bytes of a frame; only an opening byte carries the real size,
	// the others carry random sizes that the block must ignore.
	task automatic feed_frame(input logic [31:0] size, input int count, input bit opens);
		for (int i = 0; i < count; i++)
			offer_byte(8'($urandom_range(0, 255)), (opens && i == 0) ? size : $urandom());
		if (opens)
			frames_started++;
	endtask

	// Stop offering and wait until every expected packet byte has come out.
	// First let the checker's pending count take in the last accepted item.
	task automatic drain_outputs();
		in_valid   <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (due_count != 0) @(posedge clk);
	endtask

	// Write one register with the block idle; allow for a dropped byte that
	// may still be in flight before touching the config.
	task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
		drain_outputs();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		reg_writes++;
	endtask

	function automatic logic [15:0] pick_max_payload();
		case ($urandom_range(0, 7))
			0: return 16'd0;
			1: return 16'd1;
			2: return 16'd2;
			3: return 16'($urandom_range(3, 8));
			4: return 16'($urandom_range(1, 20));
			5: return 16'hFFFF;
			6: return MAX_PAYLOAD_RST;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	initial begin
		int budget;
		int len;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: one-byte frame, a dropped zero-size opener, a short
		// frame whose later size fields are extremes
		offer_byte(8'h00, 32'd1);
		frames_started++;
		offer_byte(8'hFF, 32'd0);
		offer_byte(8'hFF, 32'd3);
		offer_byte(8'h00, 32'hFFFF_FFFF);
		offer_byte(8'hA5, 32'd0);
		frames_started++;

		// zero max_payload acts as one: first, middle and last packets
		write_reg(REG_MAX_PAYLOAD, 16'd0);
		write_reg(REG_PACKET_TYPE, 16'h00FF);
		feed_frame(32'd3, 3, 1'b1);

		write_reg(REG_MAX_PAYLOAD, 16'hFFFF);
		write_reg(REG_PACKET_TYPE, 16'h005A);
		feed_frame(32'd2, 2, 1'b1);

		// change both registers in the middle of a frame
		write_reg(REG_MAX_PAYLOAD, 16'd4);
		write_reg(REG_PACKET_TYPE, 16'h0001);
		feed_frame(32'd10, 5, 1'b1);
		write_reg(REG_MAX_PAYLOAD, 16'd2);
		write_reg(REG_PACKET_TYPE, 16'h0080);
		feed_frame(32'd10, 5, 1'b0);

		// random phases: new settings each phase, frames of random length that
		// may straddle a phase boundary, and some dropped zero-size openers
		for (int phase = 0; random_sent < RANDOM_ITEMS; phase++) begin
			write_reg(REG_MAX_PAYLOAD, pick_max_payload());
			case ($urandom_range(0, 3))
				0: write_reg(REG_PACKET_TYPE, 16'h0000);
				1: write_reg(REG_PACKET_TYPE, 16'h00FF);
				default: write_reg(REG_PACKET_TYPE, 16'($urandom_range(0, 255)));
			endcase
			if (phase == 1)
				hold_req = 1'b1;
			budget = $urandom_range(15, 35);
			for (int k = 0; k < budget; k++) begin
				if (frame_left == 0) begin
					if ($urandom_range(0, 9) == 0)
						offer_byte(8'($urandom_range(0, 255)), 32'd0);
					len = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 48)
						: $urandom_range(1, 12);
					frame_left = len;
					frames_started++;
					offer_byte(8'($urandom_range(0, 255)), len);
				end else begin
					offer_byte(8'($urandom_range(0, 255)), $urandom());
				end
				frame_left--;
				random_sent++;
			end
		end

		// close any open frame, then start one of the largest size
		while (frame_left > 0) begin
			offer_byte(8'($urandom_range(0, 255)), $urandom());
			frame_left--;
		end
		write_reg(REG_MAX_PAYLOAD, 16'd3);
		write_reg(REG_PACKET_TYPE, 16'h00C3);
		feed_frame(32'hFFFF_FFFF, 8, 1'b1);

		drain_outputs();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("tb: %0d input items in %0d frames, %0d register writes, %0d long stalls",
			bytes_sent, frames_started, reg_writes, holds_done);
		$display("tb: %0d packet bytes compared, %0d mismatches", compared_count, fail_count);
		if (fail_count == 0 && due_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
